>>> rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_W        = 8;
   localparam int SYM_IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   // request tdata: symbol, entry_valid, code_bits, code_length, zero fill
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 3;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   // one classified encode item between front and back
   typedef struct packed {
      logic              err;
      logic              last;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } item_type;

   // queue status toward producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // one result
   typedef struct packed {
      logic       err;
      logic       stream_end;
      logic       last_run;
      logic       has_byte;
      logic [7:0] out_byte;
   } result_type;

endpackage

>>> rtl/huffman_code_bit_packer.sv
// Top level of the table-driven Huffman code bit packer.
// An encode item passes the registered table read, the queue and the
// back end's working registers before its first result is registered at
// the output. The back end packs one output byte per cycle unless the
// response channel stalls; leftover bits then go into the accumulator.
// Reset: synchronous; clears the present marks, accumulator, queue and output.
module huffman_code_bit_packer (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] symbol, [8] entry_valid, [40:9] code_bits, [46:41] code_length,
   // [47] zero
   input  logic [hcbp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] operation (0 = table write, 1 = encode)
   input  logic                              req_tuser,
   input  logic                              req_tlast,   // last_symbol
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_byte
   output logic [hcbp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] has_byte, [1] stream_end, [2] symbol_error
   output logic [hcbp_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast    // last_of_run
);
   import hcbp_pkg::*;

   logic             push_valid, pop;
   item_type         push_item, head;
   queue_status_type queue_status;
   result_type       rsp_result;

   // front: owns table, symbol lookup; one request per cycle unless stalled
   hcbp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .push_valid   (push_valid),
      .push_item    (push_item),
      .queue_status (queue_status)
   );

   // decouples lookup from packing so each side stalls on its own
   hcbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   // back: bit packer with registered output
   hcbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_result   (rsp_result)
   );

   assign rsp_tdata = rsp_result.out_byte;
   assign rsp_tuser = {rsp_result.err, rsp_result.stream_end, rsp_result.has_byte};
   assign rsp_tlast = rsp_result.last_run;

endmodule

>>> rtl/hcbp_front.sv
// Front end: accepts requests, owns the code table, classifies encode items.
module hcbp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hcbp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              push_valid,
   output hcbp_pkg::item_type                push_item,
   input  hcbp_pkg::queue_status_type        queue_status
);
   import hcbp_pkg::*;

   logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
   logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] present_ff, present_in;

   logic [CODE_W-1:0] rd_code_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_err_ff, s1_last_ff;

   logic                 accept, do_write, do_encode, in_range, push;
   logic [SYM_W-1:0]     sym;
   logic [SYM_IDX_W-1:0] idx;
   logic                 entry_valid;
   logic [CODE_W-1:0]    code;
   logic [LEN_W-1:0]     len, len_sat;

   assign sym         = req_tdata[SYM_W-1:0];
   assign entry_valid = req_tdata[SYM_W];
   assign code        = req_tdata[SYM_W+CODE_W:SYM_W+1];
   assign len         = req_tdata[SYM_W+CODE_W+LEN_W:SYM_W+CODE_W+1];
   assign idx         = sym[SYM_IDX_W-1:0];
   assign in_range    = {1'b0, sym} < (SYM_W+1)'(SYMBOL_COUNT);
   assign len_sat     = (len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len;

   assign push       = s1_valid_ff && !queue_status.full;
   assign req_tready = !s1_valid_ff || !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign do_write   = accept && (req_tuser == OP_WRITE) && in_range;
   assign do_encode  = accept && (req_tuser == OP_ENCODE);

   always_comb begin
      present_in = present_ff;
      if (do_write) begin
         present_in[idx] = entry_valid;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (do_encode) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (do_write) begin
         code_mem[idx] <= code;
         len_mem[idx]  <= len_sat;
      end
      if (do_encode) begin
         rd_code_ff <= code_mem[idx];
         rd_len_ff  <= len_mem[idx];
         s1_err_ff  <= !in_range || !present_ff[idx];
         s1_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         present_ff  <= present_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign push_valid     = push;
   assign push_item.err  = s1_err_ff;
   assign push_item.last = s1_last_ff;
   assign push_item.len  = rd_len_ff;
   assign push_item.code = rd_code_ff;

endmodule

>>> rtl/hcbp_queue.sv
// Short FIFO of classified items between front and back.
module hcbp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  hcbp_pkg::item_type          push_item,
   input  logic                        pop,
   output hcbp_pkg::item_type          head,
   output hcbp_pkg::queue_status_type  status
);
   import hcbp_pkg::*;

   item_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/hcbp_back.sv
// Back end: bit accumulator packs codes to bytes, one per unstalled cycle.
module hcbp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  hcbp_pkg::item_type          head,
   input  hcbp_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output hcbp_pkg::result_type        rsp_result
);
   import hcbp_pkg::*;

   logic              active_ff, active_in;
   logic              err_ff, err_in, last_ff, last_in;
   logic [CODE_W-1:0] code_w_ff, code_w_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [6:0]        acc_ff, acc_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic       out_free, need_out, done, fire;
   result_type res;
   logic [6:0] total;
   logic [5:0] rem_after;
   logic [3:0] take;
   logic [7:0] top8, acc8, byte_full, acc_new8, pad8;
   logic [6:0] acc_step;
   logic [2:0] cnt_step;
   logic [CODE_W-1:0] code_step;
   logic [LEN_W-1:0]  rem_step;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign total     = {4'b0, cnt_ff} + {1'b0, rem_ff};
   assign rem_after = 6'(total - 7'd8);
   assign take      = 4'd8 - {1'b0, cnt_ff};
   assign top8      = code_w_ff[CODE_W-1:CODE_W-8];
   assign acc8      = {1'b0, acc_ff};
   assign byte_full = 8'(acc8 << take) | (top8 >> cnt_ff);
   assign acc_new8  = 8'(acc8 << rem_ff[2:0]) | (top8 >> (4'd8 - {1'b0, rem_ff[2:0]}));
   assign pad8      = 8'(acc_new8 << (4'd8 - total[3:0]));

   // one packing step on the working item
   always_comb begin
      need_out  = 1'b0;
      done      = 1'b0;
      res       = '0;
      acc_step  = acc_ff;
      cnt_step  = cnt_ff;
      code_step = code_w_ff;
      rem_step  = rem_ff;
      if (err_ff) begin
         // stream aborted, pending bits dropped
         need_out       = 1'b1;
         done           = 1'b1;
         res.err        = 1'b1;
         res.last_run   = 1'b1;
         res.stream_end = 1'b1;
         acc_step       = '0;
         cnt_step       = '0;
      end else if (total >= 7'd8) begin
         need_out       = 1'b1;
         done           = (rem_after == '0);
         res.out_byte   = byte_full;
         res.has_byte   = 1'b1;
         res.last_run   = (rem_after < 6'd8) && (!last_ff || (rem_after == '0));
         res.stream_end = last_ff && (rem_after == '0);
         acc_step       = '0;
         cnt_step       = '0;
         code_step      = code_w_ff << take;
         rem_step       = rem_after;
      end else begin
         // remaining bits fit in the accumulator
         done     = 1'b1;
         rem_step = '0;
         if (last_ff) begin
            need_out       = 1'b1;
            res.has_byte   = (total != '0);
            res.out_byte   = (total != '0) ? pad8 : 8'd0;
            res.last_run   = 1'b1;
            res.stream_end = 1'b1;
            acc_step       = '0;
            cnt_step       = '0;
         end else begin
            acc_step = acc_new8[6:0];
            cnt_step = total[2:0];
         end
      end
   end

   assign fire = active_ff && (!need_out || out_free);
   assign pop  = !queue_status.empty && (!active_ff || (fire && done));

   always_comb begin
      active_in = active_ff;
      err_in    = err_ff;
      last_in   = last_ff;
      code_w_in = code_w_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      if (fire) begin
         acc_in    = acc_step;
         cnt_in    = cnt_step;
         code_w_in = code_step;
         rem_in    = rem_step;
         if (done) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         err_in    = head.err;
         last_in   = head.last;
         code_w_in = head.code << (LEN_W'(CODE_W) - head.len);
         rem_in    = head.err ? '0 : head.len;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire && need_out) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      last_ff   <= last_in;
      code_w_ff <= code_w_in;
      rem_ff    <= rem_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

>>> rtl/hcbp_checker.sv
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // error result is a bare, final end marker
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> !rsp_tuser[0] && rsp_tuser[1] && rsp_tlast
         && (rsp_tdata == 8'd0))
      else $error("malformed error result");

   // end of stream is always the last result of its transfer
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("stream end without last of run");

   // a result without data is a zero, final marker
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == 8'd0) && rsp_tlast && rsp_tuser[1])
      else $error("bare marker carries data or is not final");

   // nothing comes out in the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind huffman_code_bit_packer hcbp_port_checks u_hcbp_port_checks (.*);
